### rtl/elf_pkg.sv
// Encoder link framer package: word layouts, codes and constants.
// No dependencies; used by every other file of the block.
`default_nettype none

package elf_pkg;

    localparam int MAX_REPLY = 16;

    localparam logic [7:0] CODE_MASK        = 8'h7F;
    localparam logic [7:0] CODE_READ_STATUS = 8'h50;
    localparam logic [7:0] ERROR_FLAG       = 8'h80;

    localparam logic [3:0] SEND_POS_MAX  = 4'd15;
    localparam logic [4:0] REPLY_CNT_MAX = 5'd31;

    typedef enum logic [1:0] {
        MODE_CMD     = 2'd0,
        MODE_RX      = 2'd1,
        MODE_TIMEOUT = 2'd2,
        MODE_IGNORE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_TX     = 2'd0,
        KIND_RX     = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TIMEOUT    = 3'd1,
        ST_PARITY     = 3'd2,
        ST_CHECKSUM   = 3'd3,
        ST_BAD_LEN    = 3'd4,
        ST_ERROR_FLAG = 3'd5,
        ST_ENC_STATUS = 3'd6,
        ST_UNEXPECTED = 3'd7
    } status_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] data_byte;
        logic       is_final;
        logic       parity_flag;
        logic [3:0] expected_len;
    } in_word_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] byte_value;
        logic [3:0] byte_index;
        status_t    status;
        logic [7:0] encoder_status;
        logic       run_last;
    } out_word_t;

    // Results produced by one accepted word: count (0..2) and the words.
    typedef struct packed {
        logic [1:0] cnt;
        out_word_t  first;
        out_word_t  second;
    } push_t;

endpackage

`default_nettype wire

### rtl/elf_if.sv
// Valid/ready channel interfaces for the encoder link framer.
// Depends on elf_pkg for the word layouts.
`default_nettype none

interface elf_in_if;
    import elf_pkg::*;
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface elf_out_if;
    import elf_pkg::*;
    logic      valid;
    logic      ready;
    out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/elf_core.sv
// Transaction state and per-word framing logic: checksum, reply tracking, status.
// Depends on elf_pkg; feeds its results to elf_outq.
`default_nettype none

module elf_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire elf_pkg::in_word_t word,
    output elf_pkg::push_t      push
);
    import elf_pkg::*;

    localparam logic [5:0] REPLY_LIMIT = 6'(MAX_REPLY);

    logic [7:0] xor_reg, xor_next;
    logic [7:0] sent_code_reg, sent_code_next;
    logic [3:0] rlen_reg, rlen_next;
    logic [3:0] pos_reg, pos_next;
    logic [4:0] count_reg, count_next;
    logic       parity_reg, parity_next;
    logic [7:0] code_reg, code_next;
    logic [7:0] third_reg, third_next;

    logic [7:0] xor_cmd;
    logic [7:0] xor_rx;
    logic       parity_rx;
    status_t    st;
    logic [7:0] enc;
    out_word_t  w0, w1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xor_reg       <= '0;
            sent_code_reg <= '0;
            rlen_reg      <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
            parity_reg    <= 1'b0;
            code_reg      <= '0;
            third_reg     <= '0;
        end
        else if (accept)
        begin
            xor_reg       <= xor_next;
            sent_code_reg <= sent_code_next;
            rlen_reg      <= rlen_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            parity_reg    <= parity_next;
            code_reg      <= code_next;
            third_reg     <= third_next;
        end
    end

    assign xor_cmd   = (pos_reg == 4'd0) ? word.data_byte : (xor_reg ^ word.data_byte);
    assign xor_rx    = xor_reg ^ word.data_byte;
    assign parity_rx = parity_reg | word.parity_flag;

    // Status priority at the closing checksum byte
    always_comb
    begin
        enc = '0;
        if (parity_rx)
            st = ST_PARITY;
        else if (xor_rx != 8'h00)
            st = ST_CHECKSUM;
        else if ((code_reg & CODE_MASK) == CODE_READ_STATUS)
        begin
            if (count_reg != 5'd3)
                st = ST_BAD_LEN;
            else
            begin
                st  = ST_ENC_STATUS;
                enc = third_reg;
            end
        end
        else if ((code_reg & ERROR_FLAG) != 8'h00)
            st = ST_ERROR_FLAG;
        else if (code_reg != sent_code_reg || count_reg != {1'b0, rlen_reg})
            st = ST_UNEXPECTED;
        else
            st = ST_OK;
    end

    always_comb
    begin
        xor_next       = xor_reg;
        sent_code_next = sent_code_reg;
        rlen_next      = rlen_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        parity_next    = parity_reg;
        code_next      = code_reg;
        third_next     = third_reg;
        w0             = '0;
        w1             = '0;
        push.cnt       = 2'd0;

        case (word.mode)
            MODE_CMD:
            begin
                xor_next = xor_cmd;
                if (pos_reg == 4'd0)
                    sent_code_next = '0;
                if (pos_reg == 4'd1)
                    sent_code_next = word.data_byte;
                if (pos_reg < SEND_POS_MAX)
                    pos_next = pos_reg + 4'd1;
                w0.kind       = KIND_TX;
                w0.byte_value = word.data_byte;
                if (!word.is_final)
                begin
                    w0.run_last = 1'b1;
                    push.cnt    = 2'd1;
                end
                else
                begin
                    w1.kind       = KIND_TX;
                    w1.byte_value = xor_cmd;
                    w1.run_last   = 1'b1;
                    push.cnt      = 2'd2;
                    xor_next      = '0;
                    rlen_next     = word.expected_len;
                    pos_next      = '0;
                    count_next    = '0;
                    parity_next   = 1'b0;
                    code_next     = '0;
                    third_next    = '0;
                end
            end
            MODE_RX:
            begin
                xor_next    = xor_rx;
                parity_next = parity_rx;
                if (!word.is_final)
                begin
                    if (count_reg == 5'd1)
                        code_next = word.data_byte;
                    if (count_reg == 5'd2)
                        third_next = word.data_byte;
                    if ({1'b0, count_reg} < REPLY_LIMIT)
                    begin
                        w0.kind       = KIND_RX;
                        w0.byte_value = word.data_byte;
                        w0.byte_index = count_reg[3:0];
                        w0.run_last   = 1'b1;
                        push.cnt      = 2'd1;
                    end
                    if (count_reg < REPLY_CNT_MAX)
                        count_next = count_reg + 5'd1;
                end
                else
                begin
                    w0.kind           = KIND_STATUS;
                    w0.status         = st;
                    w0.encoder_status = enc;
                    w0.run_last       = 1'b1;
                    push.cnt          = 2'd1;
                    pos_next          = '0;
                end
            end
            MODE_TIMEOUT:
            begin
                w0.kind     = KIND_STATUS;
                w0.status   = ST_TIMEOUT;
                w0.run_last = 1'b1;
                push.cnt    = 2'd1;
                pos_next    = '0;
            end
            default:
            begin
            end
        endcase

        push.first  = w0;
        push.second = w1;
        if (!accept)
            push.cnt = 2'd0;
    end

endmodule

`default_nettype wire

### rtl/elf_outq.sv
// Four-entry result queue; takes up to two words per cycle, gives one per cycle while ready is high.
// Depends on elf_pkg; sits between elf_core and the result channel.
`default_nettype none

module elf_outq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire elf_pkg::push_t  push,
    output logic                 room,
    output logic                 valid,
    input  wire logic            ready,
    output elf_pkg::out_word_t   data
);
    import elf_pkg::*;

    out_word_t  mem_reg [4];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;

    assign valid = (cnt_reg != 3'd0);
    assign room  = (cnt_reg <= 3'd2);
    assign data  = mem_reg[rd_reg];
    assign pop   = valid & ready;

    always_comb
    begin
        wr_next  = wr_reg + push.cnt;
        rd_next  = rd_reg + {1'b0, pop};
        cnt_next = cnt_reg + {1'b0, push.cnt} - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem_reg[wr_reg] <= push.first;
        if (push.cnt == 2'd2)
            mem_reg[wr_reg + 2'd1] <= push.second;
    end

endmodule

`default_nettype wire

### rtl/encoder_link_transaction_framer.sv
// Encoder link transaction framer: XOR-checksummed command/reply framing.
// Each result word is registered in the result queue when its input word is accepted, and offered from there.
// Throughput: one input word per cycle while the queue has room; the result side gives one word per cycle
// while result.ready is high, so a final command byte (two results) is offered as two words in turn.
// Input is taken while the four-entry result queue has room for two words.
// Reset (rst_n, async, active low) clears transaction state and empties the queue.
`default_nettype none

module encoder_link_transaction_framer (
    input  wire logic clk,
    input  wire logic rst_n,
    elf_in_if.sink    item,
    elf_out_if.source result
);
    import elf_pkg::*;

    push_t push;
    logic  room;
    logic  accept;

    assign item.ready = room;
    assign accept     = item.valid & room;

    elf_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .word   (item.data),
        .push   (push)
    );

    elf_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .valid (result.valid),
        .ready (result.ready),
        .data  (result.data)
    );

endmodule

`default_nettype wire

### dv/encoder_link_transaction_framer_tb.sv
// Self-checking testbench for encoder_link_transaction_framer: directed and random
// command/reply transactions, predicted in-bench and checked word by word.
// Depends on elf_pkg and the elf_in_if / elf_out_if channel interfaces.
module encoder_link_transaction_framer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import elf_pkg::*;

    typedef struct {
        in_word_t w;
        bit       hold;
        bit       calm;
    } pending_entry_t;

    logic clk = 1'b0;
    logic rst_n;

    elf_in_if  item_bus ();
    elf_out_if result_bus ();

    encoder_link_transaction_framer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus)
    );

    pending_entry_t pending_words[$];
    out_word_t      expected_words[$];

    int  word_total   = 0;
    int  result_count = 0;
    int  mismatches   = 0;
    bit  gen_hold     = 0;
    bit  gen_calm     = 0;
    bit  quiet        = 0;
    int  send_idle    = 0;
    int  settle       = 0;
    int  stall_left   = 0;

    // framer state as predicted
    logic [7:0] chk_acc;
    logic [7:0] want_code;
    logic [3:0] want_len;
    logic [3:0] cmd_pos;
    logic [4:0] rx_count;
    logic       par_hit;
    logic [7:0] got_code;
    logic [7:0] got_third;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic out_word_t make_word(kind_t k, logic [7:0] v, logic [3:0] i,
                                            status_t s, logic [7:0] e, logic l);
        out_word_t r;
        r.kind           = k;
        r.byte_value     = v;
        r.byte_index     = i;
        r.status         = s;
        r.encoder_status = e;
        r.run_last       = l;
        return r;
    endfunction

    function automatic void frame_predict(in_word_t w);
        status_t    st;
        logic [7:0] enc;
        st  = ST_OK;
        enc = 8'h00;
        case (w.mode)
            MODE_CMD:
            begin
                if (cmd_pos == 4'd0)
                begin
                    chk_acc   = w.data_byte;
                    want_code = 8'h00;
                end
                else
                    chk_acc = chk_acc ^ w.data_byte;
                if (cmd_pos == 4'd1)
                    want_code = w.data_byte;
                if (cmd_pos < SEND_POS_MAX)
                    cmd_pos = cmd_pos + 4'd1;
                if (!w.is_final)
                    expected_words.push_back(make_word(KIND_TX, w.data_byte, 4'd0, ST_OK,
                                                       8'h00, 1'b1));
                else
                begin
                    expected_words.push_back(make_word(KIND_TX, w.data_byte, 4'd0, ST_OK,
                                                       8'h00, 1'b0));
                    expected_words.push_back(make_word(KIND_TX, chk_acc, 4'd0, ST_OK,
                                                       8'h00, 1'b1));
                    chk_acc   = 8'h00;
                    want_len  = w.expected_len;
                    cmd_pos   = 4'd0;
                    rx_count  = 5'd0;
                    par_hit   = 1'b0;
                    got_code  = 8'h00;
                    got_third = 8'h00;
                end
            end
            MODE_RX:
            begin
                chk_acc = chk_acc ^ w.data_byte;
                par_hit = par_hit | w.parity_flag;
                if (!w.is_final)
                begin
                    if (rx_count == 5'd1)
                        got_code = w.data_byte;
                    if (rx_count == 5'd2)
                        got_third = w.data_byte;
                    if (rx_count < MAX_REPLY)
                        expected_words.push_back(make_word(KIND_RX, w.data_byte,
                                                           rx_count[3:0], ST_OK, 8'h00, 1'b1));
                    if (rx_count < REPLY_CNT_MAX)
                        rx_count = rx_count + 5'd1;
                end
                else
                begin
                    if (par_hit)
                        st = ST_PARITY;
                    else if (chk_acc != 8'h00)
                        st = ST_CHECKSUM;
                    else if ((got_code & CODE_MASK) == CODE_READ_STATUS)
                    begin
                        if (rx_count != 5'd3)
                            st = ST_BAD_LEN;
                        else
                        begin
                            st  = ST_ENC_STATUS;
                            enc = got_third;
                        end
                    end
                    else if ((got_code & ERROR_FLAG) != 8'h00)
                        st = ST_ERROR_FLAG;
                    else if (got_code != want_code || rx_count != {1'b0, want_len})
                        st = ST_UNEXPECTED;
                    expected_words.push_back(make_word(KIND_STATUS, 8'h00, 4'd0, st, enc, 1'b1));
                    cmd_pos = 4'd0;
                end
            end
            MODE_TIMEOUT:
            begin
                expected_words.push_back(make_word(KIND_STATUS, 8'h00, 4'd0, ST_TIMEOUT,
                                                   8'h00, 1'b1));
                cmd_pos = 4'd0;
            end
            default:
                ;
        endcase
    endfunction

    task automatic queue_word(mode_t m, logic [7:0] d, logic f, logic p, logic [3:0] e);
        pending_entry_t ent;
        ent.w.mode         = m;
        ent.w.data_byte    = d;
        ent.w.is_final     = f;
        ent.w.parity_flag  = p;
        ent.w.expected_len = e;
        ent.hold           = gen_hold;
        ent.calm           = gen_calm;
        gen_hold           = 0;
        pending_words.push_back(ent);
        if (m != MODE_IGNORE)
            word_total++;
    endtask

    task automatic queue_transaction();
        int         n_cmd;
        int         n_rep;
        int         pick;
        int         bad_at;
        int         k;
        logic [7:0] cmd_code;
        logic [7:0] code;
        logic [7:0] b;
        logic [7:0] acc;
        logic [3:0] elen;
        bit         timeout_end;
        bit         bad_sum;
        bit         par_err;
        pick = $urandom_range(0, 99);
        if (pick >= 96)
        begin
            // noise: any mode, any fields
            repeat ($urandom_range(1, 6))
                queue_word(mode_t'($urandom_range(0, 3)), 8'($urandom),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           4'($urandom));
            return;
        end
        k = $urandom_range(0, 99);
        if (k < 5)
            n_cmd = 1;
        else if (k < 8)
            n_cmd = $urandom_range(15, 18);
        else
            n_cmd = $urandom_range(2, 5);
        elen     = 4'($urandom);
        cmd_code = 8'h00;
        for (k = 0; k < n_cmd; k++)
        begin
            b = 8'($urandom);
            if (k == 1)
                cmd_code = b;
            queue_word(MODE_CMD, b, k == n_cmd - 1, 1'($urandom_range(0, 1)),
                       (k == n_cmd - 1) ? elen : 4'($urandom));
        end
        n_rep       = elen;
        code        = cmd_code;
        bad_sum     = 0;
        par_err     = 0;
        timeout_end = 0;
        if (pick < 45)
            ;
        else if (pick < 55)
        begin
            code  = $urandom_range(0, 1) ? (CODE_READ_STATUS | ERROR_FLAG) : CODE_READ_STATUS;
            n_rep = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 3;
        end
        else if (pick < 62)
            code = cmd_code | ERROR_FLAG;
        else if (pick < 70)
        begin
            if ($urandom_range(0, 1))
                code = 8'($urandom);
            else
                n_rep = $urandom_range(0, 15);
        end
        else if (pick < 77)
            bad_sum = 1;
        else if (pick < 84)
            par_err = 1;
        else if (pick < 91)
        begin
            timeout_end = 1;
            n_rep       = $urandom_range(0, elen);
        end
        else
            n_rep = $urandom_range(0, 1) ? $urandom_range(16, 20) : $urandom_range(31, 34);
        bad_at = par_err ? $urandom_range(0, n_rep) : -1;
        acc    = 8'h00;
        for (k = 0; k < n_rep; k++)
        begin
            b   = (k == 1) ? code : 8'($urandom);
            acc = acc ^ b;
            queue_word(MODE_RX, b, 1'b0, k == bad_at, 4'($urandom));
        end
        if (timeout_end)
            queue_word(MODE_TIMEOUT, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0,
                       4'($urandom));
        else
            queue_word(MODE_RX, acc ^ (bad_sum ? 8'($urandom_range(1, 255)) : 8'h00), 1'b1,
                       n_rep == bad_at, 4'($urandom));
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at result %0d: %s got %0h want %0h", result_count, what, got, want);
        mismatches++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_bus.valid <= 1'b0;
            item_bus.data  <= '0;
            quiet          <= 1'b0;
            send_idle       = 0;
            settle          = 0;
            chk_acc         = 8'h00;
            want_code       = 8'h00;
            want_len        = 4'd0;
            cmd_pos         = 4'd0;
            rx_count        = 5'd0;
            par_hit         = 1'b0;
            got_code        = 8'h00;
            got_third       = 8'h00;
        end
        else
        begin : drive
            pending_entry_t nxt;
            if (item_bus.valid && item_bus.ready)
                frame_predict(item_bus.data);
            if (!item_bus.valid || item_bus.ready)
            begin
                if (pending_words.size() == 0)
                    item_bus.valid <= 1'b0;
                else if (pending_words[0].hold && (expected_words.size() != 0 || settle < 4))
                begin
                    item_bus.valid <= 1'b0;
                    settle = (expected_words.size() != 0) ? 0 : settle + 1;
                end
                else if (!pending_words[0].calm && send_idle > 0)
                begin
                    item_bus.valid <= 1'b0;
                    send_idle--;
                end
                else
                begin
                    nxt = pending_words.pop_front();
                    item_bus.data  <= nxt.w;
                    item_bus.valid <= 1'b1;
                    quiet          <= nxt.calm;
                    settle = 0;
                    if (!nxt.calm && $urandom_range(0, 9) == 0)
                        send_idle = $urandom_range(1, 8);
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            stall_left        = 0;
        end
        else
        begin : observe
            out_word_t got;
            out_word_t want;
            if (result_bus.valid && result_bus.ready)
            begin
                got = result_bus.data;
                if (expected_words.size() == 0)
                    report_mismatch("word with nothing expected", got, 0);
                else
                begin
                    want = expected_words.pop_front();
                    if (got.kind !== want.kind)
                        report_mismatch("kind", got.kind, want.kind);
                    if (got.byte_value !== want.byte_value)
                        report_mismatch("byte_value", got.byte_value, want.byte_value);
                    if (got.byte_index !== want.byte_index)
                        report_mismatch("byte_index", got.byte_index, want.byte_index);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.encoder_status !== want.encoder_status)
                        report_mismatch("encoder_status", got.encoder_status,
                                        want.encoder_status);
                    if (got.run_last !== want.run_last)
                        report_mismatch("run_last", got.run_last, want.run_last);
                end
                result_count++;
            end
            if (quiet)
                result_bus.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                result_bus.ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                result_bus.ready <= 1'b0;
                stall_left = $urandom_range(1, 8) - 1;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n = 1'b0;

        // directed: ignored mode, stray reply byte, timeout with nothing received
        queue_word(MODE_IGNORE, 8'hFF, 1'b1, 1'b1, 4'hF);
        queue_word(MODE_RX, 8'h00, 1'b0, 1'b0, 4'h0);
        queue_word(MODE_TIMEOUT, 8'h00, 1'b0, 1'b0, 4'h0);
        // one-byte command, then a bad checksum
        queue_word(MODE_CMD, 8'hFF, 1'b1, 1'b0, 4'h0);
        queue_word(MODE_RX, 8'hAA, 1'b1, 1'b0, 4'h0);
        // encoder status read
        queue_word(MODE_CMD, 8'h00, 1'b0, 1'b0, 4'h0);
        queue_word(MODE_CMD, CODE_READ_STATUS, 1'b1, 1'b0, 4'd3);
        queue_word(MODE_RX, 8'h00, 1'b0, 1'b0, 4'h0);
        queue_word(MODE_RX, CODE_READ_STATUS, 1'b0, 1'b0, 4'h0);
        queue_word(MODE_RX, 8'hA5, 1'b0, 1'b0, 4'h0);
        queue_word(MODE_RX, 8'hF5, 1'b1, 1'b0, 4'h0);
        // error flag in the reply code
        queue_word(MODE_CMD, 8'h7F, 1'b0, 1'b0, 4'h0);
        queue_word(MODE_CMD, 8'h42, 1'b1, 1'b0, 4'd2);
        queue_word(MODE_RX, 8'h7F, 1'b0, 1'b0, 4'h0);
        queue_word(MODE_RX, 8'hC2, 1'b0, 1'b0, 4'h0);
        queue_word(MODE_RX, 8'hBD, 1'b1, 1'b0, 4'h0);
        // parity error on the checksum byte
        queue_word(MODE_CMD, 8'h01, 1'b1, 1'b0, 4'h0);
        queue_word(MODE_RX, 8'h01, 1'b1, 1'b1, 4'h0);
        // timeout after one reply byte
        queue_word(MODE_CMD, 8'h80, 1'b0, 1'b0, 4'h0);
        queue_word(MODE_CMD, 8'h80, 1'b1, 1'b0, 4'hF);
        queue_word(MODE_RX, 8'h80, 1'b0, 1'b0, 4'h0);
        queue_word(MODE_TIMEOUT, 8'h00, 1'b0, 1'b0, 4'h0);
        // clean transaction after a full drain
        gen_hold = 1;
        queue_word(MODE_CMD, 8'h12, 1'b0, 1'b0, 4'h0);
        queue_word(MODE_CMD, 8'h34, 1'b1, 1'b0, 4'd2);
        queue_word(MODE_RX, 8'h12, 1'b0, 1'b0, 4'h0);
        queue_word(MODE_RX, 8'h34, 1'b0, 1'b0, 4'h0);
        queue_word(MODE_RX, 8'h26, 1'b1, 1'b0, 4'h0);

        for (int txn = 0; word_total < 1126; txn++)
        begin
            gen_calm = (word_total >= 950);
            if (txn % 150 == 149)
                gen_hold = 1;
            queue_transaction();
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_words.size() != 0 || item_bus.valid)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("timeout with %0d words still expected", expected_words.size());
        $display("status: fail");
        $finish;
    end

endmodule
